### hdl/u2t_pkg.sv
`default_nettype none

package u2t_pkg;

    localparam logic [7:0]  REPL_BYTE  = 8'h3F;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO    = 21'h000080;
    localparam logic [20:0] MIN_THREE  = 21'h000800;
    localparam logic [20:0] MIN_FOUR   = 21'h010000;
    localparam logic [20:0] ASCII_MAX  = 21'h00007F;
    localparam logic [20:0] THAI_LO    = 21'h000E01;
    localparam logic [20:0] THAI_HI    = 21'h000E5B;
    localparam logic [7:0]  THAI_BASE  = 8'hA1;
    localparam logic [20:0] NBSP_CP    = 21'h0000A0;
    localparam logic [7:0]  NBSP_BYTE  = 8'hA0;
    localparam logic [20:0] LATIN_LO   = 21'h0000FC;
    localparam logic [20:0] LATIN_HI   = 21'h0000FF;

    localparam int PUNCT_COUNT = 27;

    localparam logic [15:0] PUNCT_CP [PUNCT_COUNT] = '{
        16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
        16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
        16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
    };

    localparam logic [7:0] PUNCT_BYTE [PUNCT_COUNT] = '{
        8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
        8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'h91,
        8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
        8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9E, 8'h9F
    };

    // What follows the run of replacement bytes in one queued request
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_BYTE,
        TAIL_CP
    } tail_kind_t;

    typedef struct packed {
        logic [2:0]  rep_count;
        tail_kind_t  tail_kind;
        logic [20:0] tail;
        logic        str_end;
    } entry_t;

    function automatic logic [7:0] map_cp(input logic [20:0] cp);
        logic [7:0] res;
        res = REPL_BYTE;
        if (cp <= ASCII_MAX) begin
            res = cp[7:0];
        end else if (cp >= THAI_LO && cp <= THAI_HI) begin
            res = THAI_BASE + 8'(cp - THAI_LO);
        end else if (cp == NBSP_CP) begin
            res = NBSP_BYTE;
        end else if (cp >= LATIN_LO && cp <= LATIN_HI) begin
            res = cp[7:0];
        end else begin
            for (int k = 0; k < PUNCT_COUNT; k++) begin
                if (cp == {5'b0, PUNCT_CP[k]}) begin
                    res = PUNCT_BYTE[k];
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hdl/u2t_if.sv
`default_nettype none

interface u2t_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       string_end;

    modport source (output valid, output data_byte, output string_end, input ready);
    modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

interface u2t_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_string_end;

    modport source (output valid, output out_byte, output run_last, output out_string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input out_string_end,
                    output ready);
endinterface

interface u2t_cfg_if;
    logic valid;
    logic ready;
    logic convert_enable;

    modport source (output valid, output convert_enable, input ready);
    modport sink   (input valid, input convert_enable, output ready);
endinterface

`default_nettype wire

### hdl/utf8_to_thai_codepage_converter.sv
// UTF-8 to Windows-874 byte converter.
// in_stream carries one UTF-8 byte per request with a string_end mark on the
// final byte; out_stream returns the converted bytes, each with run_last set on
// the final byte caused by one input request and out_string_end on the final
// byte of the string. cfg writes convert_enable (0 raw pass-through, 1 convert);
// write it only while no request is in flight.
// A request accepted on in_stream is written into the queue, then its first
// byte into the output register that drives out_stream. One input request
// is taken per cycle while each causes at most one byte and the receiver is
// ready; the output register emits one byte per cycle while the receiver is
// ready, so a request that causes n bytes holds the output until all n are
// out; a request that only advances a multi-byte sequence causes none. The
// queue of QUEUE_DEPTH requests between decoder and output absorbs such bursts.
// Reset clears the mode to raw, drops any pending sequence and empties the
// queue. When the receiver stalls, the output register holds its byte, the
// queue fills, and in_stream.ready drops once it is full.
`default_nettype none

module utf8_to_thai_codepage_converter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    u2t_in_if.sink      in_stream,
    u2t_out_if.source   out_stream,
    u2t_cfg_if.sink     cfg
);

    u2t_pkg::entry_t push_entry;
    u2t_pkg::entry_t head;
    logic            push;
    logic            pop;
    logic            empty;
    logic            full;

    // decode front: classify each request into a run of '?' plus an optional tail
    u2t_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .cfg        (cfg),
        .queue_full (full),
        .push_entry (push_entry),
        .push       (push)
    );

    // hold decoded requests so front and output stall independently
    u2t_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    // output stage: expand each request into bytes, map code points
    u2t_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_stream (out_stream)
    );

endmodule

`default_nettype wire

### hdl/u2t_front.sv
`default_nettype none

module u2t_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    u2t_in_if.sink             in_stream,
    u2t_cfg_if.sink            cfg,
    input  wire logic          queue_full,
    output u2t_pkg::entry_t    push_entry,
    output logic               push
);

    logic        en_reg,    en_next;
    logic [20:0] pc_reg,    pc_next;
    logic [1:0]  exp_reg,   exp_next;
    logic [1:0]  taken_reg, taken_next;

    logic        accept;
    logic        fresh;
    logic [20:0] cp_new;
    logic [1:0]  taken_inc;
    logic [20:0] min_val;
    logic [7:0]  b;
    u2t_pkg::entry_t ent;

    assign in_stream.ready = !queue_full;
    assign cfg.ready       = 1'b1;
    assign accept          = in_stream.valid && in_stream.ready;
    assign b               = in_stream.data_byte;
    assign cp_new          = {pc_reg[14:0], b[5:0]};
    assign taken_inc       = taken_reg + 2'd1;

    always_comb
    begin
        unique case (exp_reg)
            2'd1:    min_val = u2t_pkg::MIN_TWO;
            2'd2:    min_val = u2t_pkg::MIN_THREE;
            default: min_val = u2t_pkg::MIN_FOUR;
        endcase
    end

    always_comb
    begin
        ent.rep_count = 3'd0;
        ent.tail_kind = u2t_pkg::TAIL_NONE;
        ent.tail      = 21'd0;
        ent.str_end   = in_stream.string_end;
        pc_next       = pc_reg;
        exp_next      = exp_reg;
        taken_next    = taken_reg;
        fresh         = 1'b0;

        if (!en_reg) begin
            ent.tail_kind = u2t_pkg::TAIL_BYTE;
            ent.tail      = {13'd0, b};
        end else begin
            if (exp_reg == 2'd0) begin
                fresh = 1'b1;
            end else if (b[7:6] == 2'b10) begin
                if (taken_inc == exp_reg) begin
                    // sequence complete: check range, then release it
                    if (cp_new < min_val || cp_new > u2t_pkg::CP_MAX ||
                        (cp_new >= u2t_pkg::SURR_LO && cp_new <= u2t_pkg::SURR_HI)) begin
                        ent.rep_count = 3'(exp_reg) + 3'd1;
                    end else begin
                        ent.tail_kind = u2t_pkg::TAIL_CP;
                        ent.tail      = cp_new;
                    end
                    pc_next    = 21'd0;
                    exp_next   = 2'd0;
                    taken_next = 2'd0;
                end else begin
                    pc_next    = cp_new;
                    taken_next = taken_inc;
                end
            end else begin
                // broken sequence: replace lead and continuations, decode byte afresh
                ent.rep_count = 3'(taken_reg) + 3'd1;
                pc_next       = 21'd0;
                exp_next      = 2'd0;
                taken_next    = 2'd0;
                fresh         = 1'b1;
            end

            if (fresh) begin
                if (!b[7]) begin
                    ent.tail_kind = u2t_pkg::TAIL_BYTE;
                    ent.tail      = {13'd0, b};
                end else if (b[7:5] == 3'b110) begin
                    pc_next  = {16'd0, b[4:0]};
                    exp_next = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    pc_next  = {17'd0, b[3:0]};
                    exp_next = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    pc_next  = {18'd0, b[2:0]};
                    exp_next = 2'd3;
                end else begin
                    ent.rep_count = ent.rep_count + 3'd1;
                end
            end

            // flush a pending sequence at string end
            if (in_stream.string_end && exp_next != 2'd0) begin
                ent.rep_count = ent.rep_count + 3'(taken_next) + 3'd1;
                pc_next       = 21'd0;
                exp_next      = 2'd0;
                taken_next    = 2'd0;
            end
        end
    end

    assign push_entry = ent;
    assign push       = accept && (ent.rep_count != 3'd0 ||
                                   ent.tail_kind != u2t_pkg::TAIL_NONE);

    always_comb
    begin
        en_next = en_reg;
        if (cfg.valid) begin
            en_next = cfg.convert_enable;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            en_reg    <= 1'b0;
            pc_reg    <= 21'd0;
            exp_reg   <= 2'd0;
            taken_reg <= 2'd0;
        end else begin
            en_reg <= en_next;
            if (cfg.valid) begin
                pc_reg    <= 21'd0;
                exp_reg   <= 2'd0;
                taken_reg <= 2'd0;
            end else if (accept) begin
                pc_reg    <= pc_next;
                exp_reg   <= exp_next;
                taken_reg <= taken_next;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/u2t_fifo.sv
`default_nettype none

module u2t_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire u2t_pkg::entry_t  push_entry,
    input  wire logic             pop,
    output u2t_pkg::entry_t       head,
    output logic                  empty,
    output logic                  full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u2t_pkg::entry_t slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign empty   = (count_reg == CW'(0));
    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

### hdl/u2t_back.sv
`default_nettype none

module u2t_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire u2t_pkg::entry_t  head,
    input  wire logic             empty,
    output logic                  pop,
    u2t_out_if.source             out_stream
);

    logic       valid_reg,  valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       end_reg;
    logic [1:0] idx_reg,    idx_next;

    logic       advance;
    logic       emit;
    logic [2:0] total;
    logic       is_last;
    logic [7:0] cur_byte;

    assign advance = !valid_reg || out_stream.ready;
    assign emit    = advance && !empty;
    assign total   = head.rep_count + 3'((head.tail_kind != u2t_pkg::TAIL_NONE) ? 1 : 0);
    assign is_last = ({1'b0, idx_reg} == total - 3'd1);
    assign pop     = emit && is_last;

    always_comb
    begin
        if ({1'b0, idx_reg} < head.rep_count) begin
            cur_byte = u2t_pkg::REPL_BYTE;
        end else begin
            unique case (head.tail_kind)
                u2t_pkg::TAIL_BYTE: cur_byte = head.tail[7:0];
                u2t_pkg::TAIL_CP:   cur_byte = u2t_pkg::map_cp(head.tail);
                default:            cur_byte = u2t_pkg::REPL_BYTE;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (advance) begin
            valid_next = emit;
        end
        if (emit) begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            byte_reg <= cur_byte;
            last_reg <= is_last;
            end_reg  <= is_last && head.str_end;
        end
    end

    assign out_stream.valid          = valid_reg;
    assign out_stream.out_byte       = byte_reg;
    assign out_stream.run_last       = last_reg;
    assign out_stream.out_string_end = end_reg;

endmodule

`default_nettype wire
